// File: sv/label_grid_boundary_marker_macros.svh
// Assertion macros for the label grid boundary marker.
// Both macros expect signals named clk and rst_n in the enclosing module.
`ifndef LABEL_GRID_BOUNDARY_MARKER_MACROS_SVH
`define LABEL_GRID_BOUNDARY_MARKER_MACROS_SVH

`ifndef SYNTH

`define LGBM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LGBM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LGBM_ASSERT_IMP(name, ante, cons, msg)

`define LGBM_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// File: sv/lgbm_pkg.sv
package lgbm_pkg;

    localparam int LABEL_BITS    = 4;
    localparam int MAX_ROW_CELLS = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int COL_BITS      = $clog2(MAX_ROW_CELLS);
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_BITS-1:0]   MIN_DIM          = CFG_BITS'(3);
    localparam logic [CFG_BITS-1:0]   MAX_WIDTH        = CFG_BITS'(MAX_ROW_CELLS);
    localparam logic [CFG_BITS-1:0]   MAX_HEIGHT       = CFG_BITS'(MAX_ROWS);
    localparam logic [CFG_BITS-1:0]   GRID_WIDTH_RST   = CFG_BITS'(64);
    localparam logic [CFG_BITS-1:0]   GRID_HEIGHT_RST  = CFG_BITS'(64);
    localparam logic [LABEL_BITS-1:0] EDGE_LABEL_RST   = LABEL_BITS'(1);
    localparam logic [LABEL_BITS-1:0] FLAT_LABEL_RST   = LABEL_BITS'(0);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT,
        CFG_EDGE_LABEL,
        CFG_FLAT_LABEL
    } cfg_index_t;

    typedef struct packed {
        logic                  rd_en;
        logic [COL_BITS-1:0]   col;
        logic [LABEL_BITS-1:0] label;
    } lgbm_store_req_t;

    typedef struct packed {
        logic                  en;
        logic [COL_BITS-1:0]   col;
        logic [LABEL_BITS-1:0] data;
    } lgbm_store_wr_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0] mid;
        logic [LABEL_BITS-1:0] right;
        logic [LABEL_BITS-1:0] up;
    } lgbm_store_rd_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  has_mid;
        logic                  border;
        logic                  last_row;
        logic                  last_col;
    } lgbm_item_t;

endpackage

// File: sv/lgbm_line_store.sv
module lgbm_line_store
    import lgbm_pkg::*;
(
    input  logic            clk,
    input  lgbm_store_req_t req,
    input  lgbm_store_wr_t  older_wr,
    output lgbm_store_rd_t  rd
);

    logic [LABEL_BITS-1:0] middle_mem [MAX_ROW_CELLS];
    logic [LABEL_BITS-1:0] older_mem  [MAX_ROW_CELLS];
    logic [LABEL_BITS-1:0] mid_reg;
    logic [LABEL_BITS-1:0] right_reg;
    logic [LABEL_BITS-1:0] up_reg;
    logic [COL_BITS-1:0]   right_col;

    assign right_col = req.col + COL_BITS'(1);

    // The middle row is read at the cell and its right neighbour, and the
    // arriving label replaces the cell's entry after the read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            mid_reg              <= middle_mem[req.col];
            right_reg            <= middle_mem[right_col];
            middle_mem[req.col]  <= req.label;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            up_reg <= older_mem[req.col];
        end
        if (older_wr.en)
        begin
            older_mem[older_wr.col] <= older_wr.data;
        end
    end

    assign rd.mid   = mid_reg;
    assign rd.right = right_reg;
    assign rd.up    = up_reg;

endmodule

// File: sv/label_grid_boundary_marker.sv
// A cell's first result passes through the item stage and then into the output register.
// Throughput: one cell per cycle while the output is not stalled; a cell of the last row gives
// two results and holds the item stage until both are pushed, so no new cell is taken before.
// Reset clears position counters, handshake state and left register, sets config defaults;
// data registers and line stores are not reset; stores are written as first rows arrive.
module label_grid_boundary_marker
    import lgbm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [LABEL_BITS-1:0]   cell_label,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LABEL_BITS-1:0]   out_label,
    output logic [ROW_BITS-1:0]     out_row,
    output logic [COL_BITS-1:0]     out_col,
    output logic                    run_last,
    output logic                    frame_end
);

    `include "label_grid_boundary_marker_macros.svh"

    logic [CFG_BITS-1:0]   grid_width_reg;
    logic [CFG_BITS-1:0]   grid_height_reg;
    logic [LABEL_BITS-1:0] edge_label_reg;
    logic [LABEL_BITS-1:0] flat_label_reg;

    logic [ROW_BITS-1:0]   row_count_reg;
    logic [ROW_BITS-1:0]   row_count_next;
    logic [COL_BITS-1:0]   col_count_reg;
    logic [COL_BITS-1:0]   col_count_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_phase_reg;
    logic                  s1_phase_next;
    lgbm_item_t            s1_item_reg;
    lgbm_item_t            s1_item_next;
    logic [LABEL_BITS-1:0] left_reg;
    logic [LABEL_BITS-1:0] left_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [LABEL_BITS-1:0] out_label_reg;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic                  run_last_reg;
    logic                  frame_end_reg;

    logic [CFG_BITS-1:0]   w_eff;
    logic [CFG_BITS-1:0]   h_eff;
    logic                  pos_restart;
    logic [ROW_BITS-1:0]   cur_row;
    logic [COL_BITS-1:0]   cur_col;
    logic [CFG_BITS-1:0]   col_inc;
    logic [CFG_BITS-1:0]   row_inc;
    logic                  in_accept;

    lgbm_store_req_t       store_req;
    lgbm_store_wr_t        older_wr;
    lgbm_store_rd_t        store_rd;

    logic                  push_ok;
    logic                  push;
    logic                  s1_done;
    logic                  s1_two;
    logic                  sel_first;
    logic                  is_edge;
    logic [LABEL_BITS-1:0] res1_label;
    logic [LABEL_BITS-1:0] push_label;
    logic [ROW_BITS-1:0]   push_row;
    logic                  push_run_last;
    logic                  push_frame_end;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            edge_label_reg  <= EDGE_LABEL_RST;
            flat_label_reg  <= FLAT_LABEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                CFG_EDGE_LABEL:  edge_label_reg  <= cfg_data[LABEL_BITS-1:0];
                CFG_FLAT_LABEL:  flat_label_reg  <= cfg_data[LABEL_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        priority if (grid_width_reg < MIN_DIM)
            w_eff = MIN_DIM;
        else if (grid_width_reg > MAX_WIDTH)
            w_eff = MAX_WIDTH;
        else
            w_eff = grid_width_reg;

        priority if (grid_height_reg < MIN_DIM)
            h_eff = MIN_DIM;
        else if (grid_height_reg > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = grid_height_reg;
    end

    // Position of the arriving cell; a position left outside the grid starts a new frame.
    assign in_accept   = in_valid && in_ready;
    assign pos_restart = (CFG_BITS'(col_count_reg) >= w_eff)
                      || (CFG_BITS'(row_count_reg) >= h_eff);
    assign cur_row     = pos_restart ? '0 : row_count_reg;
    assign cur_col     = pos_restart ? '0 : col_count_reg;
    assign col_inc     = CFG_BITS'(cur_col) + CFG_BITS'(1);
    assign row_inc     = CFG_BITS'(cur_row) + CFG_BITS'(1);

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_count_next = '0;
                row_count_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
            end
            else
            begin
                col_count_next = col_inc[COL_BITS-1:0];
                row_count_next = cur_row;
            end
        end
    end

    always_comb
    begin
        s1_item_next.label    = cell_label;
        s1_item_next.row      = cur_row;
        s1_item_next.col      = cur_col;
        s1_item_next.has_mid  = (cur_row != '0);
        s1_item_next.border   = (cur_row == ROW_BITS'(1)) || (cur_col == '0)
                             || (col_inc == w_eff);
        s1_item_next.last_row = (row_inc == h_eff);
        s1_item_next.last_col = (col_inc == w_eff);
    end

    assign store_req.rd_en = in_accept;
    assign store_req.col   = cur_col;
    assign store_req.label = cell_label;

    assign older_wr.en   = s1_done && s1_item_reg.has_mid;
    assign older_wr.col  = s1_item_reg.col;
    assign older_wr.data = store_rd.mid;

    lgbm_line_store u_line_store (
        .clk      (clk),
        .req      (store_req),
        .older_wr (older_wr),
        .rd       (store_rd)
    );

    // Item stage: the row above is emitted first, then the cell itself on the last row.
    assign is_edge    = (store_rd.up != s1_item_reg.label) || (left_reg != store_rd.right);
    assign res1_label = s1_item_reg.border ? store_rd.mid
                      : (is_edge ? edge_label_reg : flat_label_reg);
    assign s1_two     = s1_item_reg.has_mid && s1_item_reg.last_row;
    assign sel_first  = s1_item_reg.has_mid && !s1_phase_reg;
    assign push_ok    = !out_valid_reg || out_ready;

    always_comb
    begin
        push    = 1'b0;
        s1_done = 1'b0;
        if (s1_valid_reg)
        begin
            if (!s1_item_reg.has_mid && !s1_item_reg.last_row)
            begin
                s1_done = 1'b1;
            end
            else if (push_ok)
            begin
                push    = 1'b1;
                s1_done = !s1_two || s1_phase_reg;
            end
        end
    end

    always_comb
    begin
        if (sel_first)
        begin
            push_label     = res1_label;
            push_row       = s1_item_reg.row - ROW_BITS'(1);
            push_run_last  = !s1_item_reg.last_row;
            push_frame_end = 1'b0;
        end
        else
        begin
            push_label     = s1_item_reg.label;
            push_row       = s1_item_reg.row;
            push_run_last  = 1'b1;
            push_frame_end = s1_item_reg.last_col;
        end
    end

    assign in_ready = !s1_valid_reg || s1_done;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        left_next     = left_reg;
        if (s1_done)
        begin
            s1_valid_next = 1'b0;
            s1_phase_next = 1'b0;
            left_next     = s1_item_reg.has_mid ? store_rd.mid : '0;
        end
        else if (push)
        begin
            s1_phase_next = 1'b1;
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (push)
        begin
            out_label_reg <= push_label;
            out_row_reg   <= push_row;
            out_col_reg   <= s1_item_reg.col;
            run_last_reg  <= push_run_last;
            frame_end_reg <= push_frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_label = out_label_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

    `LGBM_ASSERT_IMP(a_two_blocks_input, s1_valid_reg && s1_two && !s1_phase_reg, !in_ready, "input taken while a two-result transaction still owes its first result")
    `LGBM_ASSERT_IMP(a_phase_only_two, s1_phase_reg, s1_valid_reg && s1_two, "second-result phase set for an item with fewer than two results")
    `LGBM_ASSERT_IMP(a_frame_end_last, out_valid && frame_end, run_last, "frame end flagged on a result that is not the last of its transaction")
    `LGBM_ASSERT_NXT(a_second_follows, out_valid && out_ready && !run_last, out_valid && run_last, "second result of a last-row transaction did not follow")

endmodule
